// ===== hw/rtl/frt_pkg.sv =====
// shared types, constants and codes of the fragment reassembly tracker
package frt_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int MAX_PIECES_DEF = 64;

	localparam logic [15:0] TIMEOUT_RESET = 16'd60;

	// configuration port
	localparam int          CFG_ADDR_W  = 3;
	localparam int          CFG_DATA_W  = 32;
	localparam logic [0:0]  REG_TIMEOUT = 1'b0;

	// stream word layout
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 32;
	localparam int SUM_W    = 22;
	localparam int EXP_W    = 5;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic OP_FRAGMENT = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_DUP      = 3'd2,
		ST_BADIDX   = 3'd3,
		ST_FULL     = 3'd4,
		ST_TOOMANY  = 3'd5,
		ST_TICK     = 3'd6
	} track_status_t;

	// classified word handed from the front end to the engine
	typedef struct packed {
		logic        is_tick;
		logic        over_max;
		logic [15:0] message_id;
		logic [7:0]  client_id;
		logic [7:0]  piece_index;
		logic [7:0]  piece_total;
		logic [15:0] payload_length;
	} cmd_t;

endpackage

// ===== hw/rtl/fragment_reassembly_tracker.sv =====
// top level of the fragment reassembly tracker: config register, front end and engine
//
// Input words arrive on s_* (tuser selects fragment or one-second tick) and one
// result word per input leaves on m_* (tuser carries the status code).
// A two-entry queue sits between the front end and the engine, so the input
// side keeps accepting while the engine works or the output is stalled; when
// the queue is full s_tready drops.
// A fragment is handled in steps, and the engine takes no new word until it
// is done: it pops the word and compares all keys in parallel, then picks the
// slot and reads its record, then updates it. A fragment rejected for a full
// table or too many pieces answers from the slot pick, with no update.
// A tick's result waits for the age sweep, which reads one slot record a
// cycle from the record memory.
// The result register holds its word while m_tready is low; the engine starts
// no new word until that register can take the next result.
// Reset clears all slots, the seconds counter and the queue and loads the
// timeout register with 60. The user must write the timeout over the APB
// port at address 0 only while the block is idle; the block does not enforce it.
module fragment_reassembly_tracker #(
	parameter int SLOTS      = frt_pkg::SLOTS_DEF,
	parameter int MAX_PIECES = frt_pkg::MAX_PIECES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: message_id, client_id, piece_index, piece_total, payload_length
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [frt_pkg::S_DATA_W-1:0]    s_tdata,
	// s_tuser: opcode
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: slot_used, slot_allocated, msg_bytes, expired_count
	output logic [frt_pkg::M_DATA_W-1:0]    m_tdata,
	// m_tuser: status
	output logic [2:0]                      m_tuser,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [frt_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [frt_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [frt_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);

	logic [15:0]   timeout_q;
	logic          reg_hit;
	logic          q_valid;
	logic          q_pop;
	frt_pkg::cmd_t q_cmd;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[frt_pkg::CFG_ADDR_W-1:2] == frt_pkg::REG_TIMEOUT);
	assign prdata  = reg_hit ? frt_pkg::CFG_DATA_W'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= frt_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			timeout_q <= pwdata[15:0];
		end
	end

	frt_front #(
		.MAX_PIECES (MAX_PIECES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	frt_engine #(
		.SLOTS      (SLOTS),
		.MAX_PIECES (MAX_PIECES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.timeout  (timeout_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== hw/rtl/frt_front.sv =====
// front end: accepts stream words, classifies them and queues them for the engine
module frt_front #(
	parameter int MAX_PIECES = frt_pkg::MAX_PIECES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [frt_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [0:0]                    s_tuser,
	output logic                          q_valid,
	output frt_pkg::cmd_t                 q_cmd,
	input  logic                          q_pop
);

	localparam int DEPTH = 2;

	frt_pkg::cmd_t fifo_q [DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	frt_pkg::cmd_t cmd_in;
	logic          push;

	always_comb begin
		cmd_in.is_tick        = (s_tuser[0] == frt_pkg::OP_TICK);
		cmd_in.message_id     = s_tdata[15:0];
		cmd_in.client_id      = s_tdata[23:16];
		cmd_in.piece_index    = s_tdata[31:24];
		cmd_in.piece_total    = s_tdata[39:32];
		cmd_in.payload_length = s_tdata[55:40];
		// a new message may not claim more pieces than a slot can track
		cmd_in.over_max       = (s_tdata[39:32] > 8'(MAX_PIECES));
	end

	assign s_tready = (cnt_q != 2'(DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/frt_engine.sv =====
// back end: slot table lookup, allocation, piece update, tick sweep and result register
module frt_engine #(
	parameter int SLOTS      = frt_pkg::SLOTS_DEF,
	parameter int MAX_PIECES = frt_pkg::MAX_PIECES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  frt_pkg::cmd_t                 q_cmd,
	output logic                          q_pop,
	input  logic [15:0]                   timeout,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [frt_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [2:0]                    m_tuser
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int PW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
	localparam int NW = $clog2(MAX_PIECES + 1);

	typedef struct packed {
		logic [NW-1:0]             total;
		logic [MAX_PIECES-1:0]     mask;
		logic [NW-1:0]             count;
		logic [frt_pkg::SUM_W-1:0] sum;
		logic [31:0]               start;
	} rec_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_UPD,
		S_TICK
	} state_t;

	state_t           state_q;
	frt_pkg::cmd_t    cmd_q;
	logic [SLOTS-1:0] valid_q;
	logic [15:0]      key_mid_q [SLOTS];
	logic [7:0]       key_cid_q [SLOTS];
	logic [SLOTS-1:0] match_s1;
	logic [SLOTS-1:0] free_s1;
	logic [IW-1:0]    slot_q;
	logic             alloc_q;
	logic [31:0]      seconds_q;
	logic [CW-1:0]    sweep_q;
	logic             chk_q;
	logic [IW-1:0]    chk_idx_q;
	logic [CW-1:0]    freed_q;

	// slot records live in a memory, one read and one write port
	rec_t             mem [SLOTS];
	rec_t             rd_q;
	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic             wr_en;
	rec_t             wr_data;

	logic                      out_valid_q;
	frt_pkg::track_status_t    out_status_q;
	logic [3:0]                out_slot_q;
	logic                      out_alloc_q;
	logic [frt_pkg::SUM_W-1:0] out_size_q;
	logic [frt_pkg::EXP_W-1:0] out_exp_q;

	logic                      start;
	logic                      found;
	logic [IW-1:0]             found_idx;
	logic                      free_any;
	logic [IW-1:0]             free_idx;
	logic                      alloc_now;
	rec_t                      rec;
	rec_t                      upd_rec;
	logic                      bad;
	logic                      dup;
	logic                      complete;
	logic [PW-1:0]             bit_idx;
	logic [frt_pkg::SUM_W:0]   sum_ext;
	logic                      sweep_done;
	logic [31:0]               age;
	logic                      expire;

	assign start = (state_q == S_IDLE) && q_valid && (!out_valid_q || m_tready);
	assign q_pop = start;

	// lowest-numbered matching and free slots
	always_comb begin
		found_idx = '0;
		free_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				found_idx = IW'(i);
			end
			if (free_s1[i]) begin
				free_idx = IW'(i);
			end
		end
		found    = |match_s1;
		free_any = |free_s1;
	end

	assign alloc_now = (state_q == S_MATCH) && !found && !cmd_q.over_max && free_any;

	// piece update on the selected record
	always_comb begin
		if (alloc_q) begin
			rec.total = NW'(cmd_q.piece_total);
			rec.mask  = '0;
			rec.count = '0;
			rec.sum   = '0;
			rec.start = seconds_q;
		end else begin
			rec = rd_q;
		end
		bit_idx       = cmd_q.piece_index[PW-1:0];
		bad           = (cmd_q.piece_index >= 8'(rec.total));
		dup           = !bad && rec.mask[bit_idx];
		upd_rec       = rec;
		upd_rec.mask  = rec.mask | (MAX_PIECES'(1) << bit_idx);
		upd_rec.count = rec.count + NW'(1);
		sum_ext       = {1'b0, rec.sum} + (frt_pkg::SUM_W + 1)'(cmd_q.payload_length);
		upd_rec.sum   = sum_ext[frt_pkg::SUM_W] ? frt_pkg::SUM_MAX : sum_ext[frt_pkg::SUM_W-1:0];
		complete      = !bad && !dup && (upd_rec.count == rec.total);
		wr_en         = (state_q == S_UPD) && (alloc_q || (!bad && !dup));
		wr_data       = (bad || dup) ? rec : upd_rec;
	end

	// tick sweep: reads one slot a cycle, judges it the cycle after
	assign sweep_done = (sweep_q == CW'(SLOTS));
	assign age        = seconds_q - rd_q.start;
	assign expire     = chk_q && valid_q[chk_idx_q] && (age > {16'd0, timeout});

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = found_idx;
		if (state_q == S_MATCH) begin
			rd_en = found;
		end else if (state_q == S_TICK && !sweep_done) begin
			rd_en   = 1'b1;
			rd_addr = sweep_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_now) begin
			key_mid_q[free_idx] <= cmd_q.message_id;
			key_cid_q[free_idx] <= cmd_q.client_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			valid_q      <= '0;
			match_s1     <= '0;
			free_s1      <= '0;
			slot_q       <= '0;
			alloc_q      <= 1'b0;
			seconds_q    <= '0;
			sweep_q      <= '0;
			chk_q        <= 1'b0;
			chk_idx_q    <= '0;
			freed_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= frt_pkg::ST_STORED;
			out_slot_q   <= '0;
			out_alloc_q  <= 1'b0;
			out_size_q   <= '0;
			out_exp_q    <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= q_cmd;
						if (q_cmd.is_tick) begin
							seconds_q <= seconds_q + 32'd1;
							sweep_q   <= '0;
							chk_q     <= 1'b0;
							freed_q   <= '0;
							state_q   <= S_TICK;
						end else begin
							for (int i = 0; i < SLOTS; i++) begin
								match_s1[i] <= valid_q[i] &&
									(key_mid_q[i] == q_cmd.message_id) &&
									(key_cid_q[i] == q_cmd.client_id);
							end
							free_s1 <= ~valid_q;
							state_q <= S_MATCH;
						end
					end
				end
				S_MATCH: begin
					if (found) begin
						slot_q  <= found_idx;
						alloc_q <= 1'b0;
						state_q <= S_UPD;
					end else if (cmd_q.over_max || !free_any) begin
						out_valid_q  <= 1'b1;
						out_status_q <= cmd_q.over_max ? frt_pkg::ST_TOOMANY : frt_pkg::ST_FULL;
						out_slot_q   <= '0;
						out_alloc_q  <= 1'b0;
						out_size_q   <= '0;
						out_exp_q    <= '0;
						state_q      <= S_IDLE;
					end else begin
						slot_q            <= free_idx;
						alloc_q           <= 1'b1;
						valid_q[free_idx] <= 1'b1;
						state_q           <= S_UPD;
					end
				end
				S_UPD: begin
					out_valid_q <= 1'b1;
					if (bad) begin
						out_status_q <= frt_pkg::ST_BADIDX;
					end else if (dup) begin
						out_status_q <= frt_pkg::ST_DUP;
					end else if (complete) begin
						out_status_q <= frt_pkg::ST_COMPLETE;
					end else begin
						out_status_q <= frt_pkg::ST_STORED;
					end
					out_slot_q  <= 4'(slot_q);
					out_alloc_q <= alloc_q;
					out_size_q  <= complete ? upd_rec.sum : '0;
					out_exp_q   <= '0;
					if (complete) begin
						valid_q[slot_q] <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				S_TICK: begin
					if (!sweep_done) begin
						sweep_q <= sweep_q + CW'(1);
					end
					chk_q     <= !sweep_done;
					chk_idx_q <= sweep_q[IW-1:0];
					if (expire) begin
						valid_q[chk_idx_q] <= 1'b0;
						freed_q            <= freed_q + CW'(1);
					end
					if (sweep_done && !chk_q) begin
						out_valid_q  <= 1'b1;
						out_status_q <= frt_pkg::ST_TICK;
						out_slot_q   <= '0;
						out_alloc_q  <= 1'b0;
						out_size_q   <= '0;
						out_exp_q    <= frt_pkg::EXP_W'(freed_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_exp_q, out_size_q, out_alloc_q, out_slot_q};

endmodule

// ===== hw/rtl/frt_checker.sv =====
// port-level checks on the result channel, bound to the top level
module frt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [frt_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [2:0]                    m_tuser
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// size only on completion
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != frt_pkg::ST_COMPLETE) |-> (m_tdata[26:5] == '0))
		else $error("message size on a non-complete result");

	// expired count only on a tick, and a tick names no slot
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == frt_pkg::ST_TICK) ? (m_tdata[4:0] == '0)
			: (m_tdata[31:27] == '0)))
		else $error("tick fields inconsistent with status");

	// rejected new messages open no slot
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == frt_pkg::ST_FULL || m_tuser == frt_pkg::ST_TOOMANY)
		|-> (m_tdata[4:0] == '0))
		else $error("rejected fragment reports a slot");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
